[hw/rtl/uxcf_pkg.sv]
`default_nettype none

package uxcf_pkg;

    // Longest string the offset counter is sized for; offsets stop at the cap.
    localparam longint unsigned MAX_STRING_BYTES = 64'd65536;
    localparam logic [15:0] OFFSET_CAP =
        ((MAX_STRING_BYTES - 64'd1) < 64'd65535) ? 16'(MAX_STRING_BYTES - 64'd1) : 16'hFFFF;

    // Entries in the queue between the decoder and the result sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Bounds of the XML 1.0 Char production.
    localparam logic [20:0] CP_TAB      = 21'h00009;
    localparam logic [20:0] CP_LF       = 21'h0000A;
    localparam logic [20:0] CP_CR       = 21'h0000D;
    localparam logic [20:0] CP_BMP_LO   = 21'h00020;
    localparam logic [20:0] CP_BMP_HI   = 21'h0D7FF;
    localparam logic [20:0] CP_PRIV_LO  = 21'h0E000;
    localparam logic [20:0] CP_PRIV_HI  = 21'h0FFFD;
    localparam logic [20:0] CP_SUPP_LO  = 21'h10000;
    localparam logic [20:0] CP_SUPP_HI  = 21'h10FFFF;

    // Smallest value each sequence length may carry without being overlong.
    localparam logic [20:0] MIN_TWO   = 21'h00080;
    localparam logic [20:0] MIN_THREE = 21'h00800;
    localparam logic [20:0] MIN_FOUR  = 21'h10000;

    // The work one input beat leaves for the back end: up to four results.
    // Slot 0 uses offset and code point A, the later slots use B.
    typedef struct packed {
        logic [2:0]       cnt;
        logic [3:0][7:0]  bytes;
        logic [3:0]       inv;
        logic [15:0]      off_a;
        logic [15:0]      off_b;
        logic [20:0]      cp_a;
        logic [20:0]      cp_b;
        logic             str_end;
        logic             failed;
    } t_entry;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // XML 1.0 Char test.
    function automatic logic xml_char_ok(input logic [20:0] c);
        logic ok;
        ok = (c == CP_TAB) || (c == CP_LF) || (c == CP_CR) ||
             (c >= CP_BMP_LO && c <= CP_BMP_HI) ||
             (c >= CP_PRIV_LO && c <= CP_PRIV_HI) ||
             (c >= CP_SUPP_LO && c <= CP_SUPP_HI);
        return ok;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/utf8_xml_char_filter_top.sv]
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_stall     i_data_byte, i_string_end
// output    o_out_valid / i_out_stall   o_out_byte, o_is_invalid, o_char_offset,
//                                       o_code_point, o_run_last, o_end_flag,
//                                       o_string_failed
//
// One byte is taken per cycle unless the queue is full; its results pass through the queue
// and the sequencer's output register, one result per cycle unless the output is stalled, so
// a byte that closes a valid four-byte character holds the output for its four results while
// the decoder runs ahead. The input stalls only when the queue between decoder and sequencer
// is full. Reset is synchronous and active low; the first string starts at offset 0.
`default_nettype none

module utf8_xml_char_filter_top import uxcf_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire logic   [7:0] i_data_byte,
    input  wire logic   i_string_end,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_invalid,
    output logic [15:0] o_char_offset,
    output logic [20:0] o_code_point,
    output logic        o_run_last,
    output logic        o_end_flag,
    output logic        o_string_failed
);

    logic   w_full;
    logic   w_push;
    logic   w_pop;
    t_entry w_entry;
    t_head  w_head;

    // Decoder: classifies each byte and builds its result slots.
    uxcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_string_end (i_string_end),
        .i_full       (w_full),
        .o_stall      (o_in_stall),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    // Queue between decoder and sequencer.
    uxcf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // Sequencer: one result beat per cycle from the queue head, unless the output is stalled.
    uxcf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_is_invalid    (o_is_invalid),
        .o_char_offset   (o_char_offset),
        .o_code_point    (o_code_point),
        .o_run_last      (o_run_last),
        .o_end_flag      (o_end_flag),
        .o_string_failed (o_string_failed)
    );

`ifndef NO_ASSERTIONS
    // A queued entry always holds between one and four results.
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_entry.cnt != 3'd0) && (w_entry.cnt <= 3'd4))
        else $error("queued entry with no or too many results");

    // The string end closes the run of results of its byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_flag |-> o_run_last)
        else $error("end flag on a result that is not last of its byte");

    // A failure is only reported together with the end of the string.
    a_fail_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_failed |-> o_end_flag)
        else $error("string failure without end flag");

    // Results of one byte leave without gaps.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last |=> o_out_valid)
        else $error("gap inside the results of one byte");
`endif

endmodule

`default_nettype wire

[hw/rtl/uxcf_front.sv]
`default_nettype none

module uxcf_front import uxcf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic   [7:0] i_data_byte,
    input  wire logic   i_string_end,
    input  wire logic   i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [1:0]        r_rem, n_rem;
    logic [1:0]        r_pcnt, n_pcnt;
    logic [20:0]       r_acc, n_acc;
    logic [15:0]       r_start, n_start;
    logic [15:0]       r_pos, n_pos;
    logic              r_anyinv, n_anyinv;
    logic [2:0][7:0]   r_pend, n_pend;
    logic              w_accept;
    t_entry            w_entry;

    assign w_accept = i_valid && !i_full;
    assign o_stall  = i_full;
    assign o_push   = w_accept && (w_entry.cnt != 3'd0);
    assign o_entry  = w_entry;

    // Decode one byte against the open character and build its result slots.
    always_comb begin
        logic        v_cont;
        logic        v_open;
        logic        v_lead;
        logic [20:0] v_lead_acc;
        logic [1:0]  v_lead_rem;
        logic [20:0] v_acc_c;
        logic [1:0]  v_rem_c;
        logic [20:0] v_min;
        logic        v_fin_ok;
        logic        v_s_inv;
        logic [1:0]  v_k;
        logic        v_failed;

        v_cont  = (i_data_byte[7:6] == 2'b10);
        v_open  = (r_rem != 2'd0);
        v_lead  = (i_data_byte inside {[8'hC0:8'hF7]});
        v_acc_c = {r_acc[14:0], i_data_byte[5:0]};
        v_rem_c = r_rem - 2'd1;
        v_s_inv = i_data_byte[7] || !xml_char_ok({13'd0, i_data_byte});

        case (i_data_byte[5:3])
            3'b100, 3'b101: begin
                v_lead_acc = {17'd0, i_data_byte[3:0]};
                v_lead_rem = 2'd2;
            end
            3'b110: begin
                v_lead_acc = {18'd0, i_data_byte[2:0]};
                v_lead_rem = 2'd3;
            end
            default: begin
                v_lead_acc = {16'd0, i_data_byte[4:0]};
                v_lead_rem = 2'd1;
            end
        endcase

        case (r_pcnt)
            2'd1:    v_min = MIN_TWO;
            2'd2:    v_min = MIN_THREE;
            default: v_min = MIN_FOUR;
        endcase
        v_fin_ok = (v_acc_c >= v_min) && xml_char_ok(v_acc_c);

        w_entry = '0;
        n_rem   = r_rem;
        n_pcnt  = r_pcnt;
        n_acc   = r_acc;
        n_start = r_start;
        n_pend  = r_pend;
        v_k     = 2'd0;

        if (v_open && v_cont) begin
            if (v_rem_c == 2'd0) begin
                // Final continuation byte: release the whole character or report it.
                n_rem  = 2'd0;
                n_pcnt = 2'd0;
                n_acc  = '0;
                w_entry.off_a = r_start;
                w_entry.off_b = r_start;
                w_entry.cp_a  = v_acc_c;
                w_entry.cp_b  = v_acc_c;
                if (v_fin_ok) begin
                    w_entry.cnt      = {1'b0, r_pcnt} + 3'd1;
                    w_entry.bytes[0] = r_pend[0];
                    w_entry.bytes[1] = (r_pcnt == 2'd1) ? i_data_byte : r_pend[1];
                    w_entry.bytes[2] = (r_pcnt == 2'd2) ? i_data_byte : r_pend[2];
                    w_entry.bytes[3] = i_data_byte;
                end else begin
                    w_entry.cnt    = 3'd1;
                    w_entry.inv[0] = 1'b1;
                end
            end else begin
                // Middle continuation byte: keep gathering.
                n_pend[r_pcnt] = i_data_byte;
                n_pcnt = r_pcnt + 2'd1;
                n_acc  = v_acc_c;
                n_rem  = v_rem_c;
                if (i_string_end) begin
                    w_entry.cnt    = 3'd1;
                    w_entry.inv[0] = 1'b1;
                    w_entry.off_a  = r_start;
                    w_entry.cp_a   = v_acc_c;
                end
            end
        end else begin
            // A broken sequence is reported first, at its own offset.
            if (v_open) begin
                w_entry.cnt    = 3'd1;
                w_entry.inv[0] = 1'b1;
                w_entry.off_a  = r_start;
                w_entry.cp_a   = r_acc;
                v_k            = 2'd1;
            end
            n_start = r_pos;
            if (!v_lead) begin
                // Single-byte character, stray continuation or bad lead.
                n_rem  = 2'd0;
                n_pcnt = 2'd0;
                n_acc  = '0;
                w_entry.cnt        = w_entry.cnt + 3'd1;
                w_entry.bytes[v_k] = v_s_inv ? 8'd0 : i_data_byte;
                w_entry.inv[v_k]   = v_s_inv;
                if (v_k == 2'd0) begin
                    w_entry.off_a = r_pos;
                    w_entry.cp_a  = {13'd0, i_data_byte};
                end else begin
                    w_entry.off_b = r_pos;
                    w_entry.cp_b  = {13'd0, i_data_byte};
                end
            end else begin
                // Lead byte opens a new character; the end of string truncates it.
                n_acc     = v_lead_acc;
                n_rem     = v_lead_rem;
                n_pend[0] = i_data_byte;
                n_pcnt    = 2'd1;
                if (i_string_end) begin
                    w_entry.cnt      = w_entry.cnt + 3'd1;
                    w_entry.inv[v_k] = 1'b1;
                    if (v_k == 2'd0) begin
                        w_entry.off_a = r_pos;
                        w_entry.cp_a  = v_lead_acc;
                    end else begin
                        w_entry.off_b = r_pos;
                        w_entry.cp_b  = v_lead_acc;
                    end
                end
            end
        end

        v_failed         = r_anyinv || (|w_entry.inv);
        n_anyinv         = v_failed;
        w_entry.str_end  = i_string_end;
        w_entry.failed   = v_failed;
        n_pos            = (r_pos < OFFSET_CAP) ? r_pos + 16'd1 : r_pos;

        // The end of a string returns all decode state to its start.
        if (i_string_end) begin
            n_rem    = 2'd0;
            n_pcnt   = 2'd0;
            n_acc    = '0;
            n_start  = '0;
            n_pos    = '0;
            n_anyinv = 1'b0;
        end
    end

    // Decode state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_pcnt   <= '0;
            r_acc    <= '0;
            r_start  <= '0;
            r_pos    <= '0;
            r_anyinv <= 1'b0;
        end else if (w_accept) begin
            r_rem    <= n_rem;
            r_pcnt   <= n_pcnt;
            r_acc    <= n_acc;
            r_start  <= n_start;
            r_pos    <= n_pos;
            r_anyinv <= n_anyinv;
        end
    end

    // Pending bytes of the open character need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/uxcf_queue.sv]
`default_nettype none

module uxcf_queue import uxcf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output t_head       o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_rp, n_rp;
    logic [CW-1:0]     r_cnt;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_head = '{valid: (r_cnt != '0), entry: r_mem[r_rp]};

    // Pointer wrap at the queue depth.
    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/uxcf_back.sv]
`default_nettype none

module uxcf_back import uxcf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_head  i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_invalid,
    output logic [15:0] o_char_offset,
    output logic [20:0] o_code_point,
    output logic        o_run_last,
    output logic        o_end_flag,
    output logic        o_string_failed
);

    logic [1:0]  r_slot;
    logic        r_valid;
    logic        w_load;
    logic        w_last;
    t_entry      w_e;

    assign w_e    = i_head.entry;
    assign w_load = i_head.valid && (!r_valid || !i_stall);
    assign w_last = ({1'b0, r_slot} == (w_e.cnt - 3'd1));
    assign o_pop  = w_load && w_last;
    assign o_valid = r_valid;

    // Slot counter and output beat valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_slot <= w_last ? 2'd0 : r_slot + 2'd1;
            end
            r_valid <= w_load || (r_valid && i_stall);
        end
    end

    // Output register, loaded with the current slot of the queue head.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_out_byte      <= w_e.bytes[r_slot];
            o_is_invalid    <= w_e.inv[r_slot];
            o_char_offset   <= (r_slot == 2'd0) ? w_e.off_a : w_e.off_b;
            o_code_point    <= (r_slot == 2'd0) ? w_e.cp_a : w_e.cp_b;
            o_run_last      <= w_last;
            o_end_flag      <= w_last && w_e.str_end;
            o_string_failed <= w_last && w_e.str_end && w_e.failed;
        end
    end

endmodule

`default_nettype wire
